// ===== rtl/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types and constants shared by the request line parser and its checker.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // byte values
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_SPACE    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN     = 3'd2;
    localparam logic [2:0] ST_NO_LINE_END = 3'd3;
    localparam logic [2:0] ST_TOO_LONG    = 3'd4;

    // method codes, table position plus one
    localparam int          NUM_METHODS  = 9;
    localparam logic [3:0]  METHOD_NONE  = 4'd0;
    localparam logic [3:0]  METHOD_LAST  = 4'd9;

    // token lengths and spellings, padded with zero bytes
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd5, 4'd7
    };

    localparam logic [7:0] METHOD_CHAR [NUM_METHODS][8] = '{
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
    };

    // parse phase, one-hot
    typedef enum logic [2:0] {
        PH_METHOD  = 3'b001,
        PH_URI     = 3'b010,
        PH_VERSION = 3'b100
    } phase_t;

    // input item
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  method_code;
        logic [15:0] uri_start;
        logic [15:0] uri_length;
        logic [15:0] version_start;
        logic [15:0] version_length;
        logic [15:0] header_offset;
    } out_item_t;

endpackage

// ===== rtl/http_request_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser_unit
// Splits an HTTP request line, one byte per item, into method, URI and version.
// ----------------------------------------------------------------------------
// Usage
//   in channel : one byte of a request buffer per item, last_byte set on the
//                final byte. Buffers follow one another with no gap.
//   out channel: exactly one result item per buffer, issued as soon as the
//                request line is decided (CRLF, error or final byte).
//   Throughput is one byte per cycle, except where a stalled result holds
//   a byte as below. Each byte is captured in an input register and evaluated
//   by compare logic, which updates the parse state and, where a result
//   falls, the result register once the byte advances. The single-cycle
//   rate is set by the parse state update, which each byte must see
//   before the next.
//   While the receiver stalls a waiting result, bytes that give no result
//   keep flowing; a byte that would give one holds in the input register
//   and in_ready stays low until the waiting result is taken.
//   Reset empties both registers and returns the parser to the method phase
//   at offset zero; the parse state rearms the same way after every final byte.
//   Offsets are counted in POS_BITS bits and reported in 16.
// ----------------------------------------------------------------------------
module http_request_line_parser_unit
    import hrlp_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // parse state
    phase_t              phase_reg,         phase_next;
    logic [POS_BITS-1:0] position_reg,      position_next;
    logic [8:0]          candidates_reg,    candidates_next;
    logic [3:0]          method_length_reg, method_length_next;
    logic                prev_cr_reg,       prev_cr_next;
    logic [POS_BITS-1:0] uri_begin_reg,     uri_begin_next;
    logic [POS_BITS-1:0] uri_end_reg,       uri_end_next;
    logic [POS_BITS-1:0] version_begin_reg, version_begin_next;
    logic                result_done_reg,   result_done_next;
    logic [3:0]          method_code_reg,   method_code_next;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      produce;
    out_item_t result;
    logic      advance;
    logic [8:0] keep;
    logic [3:0] exact_code;
    logic       crlf;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign cur_byte = in_item_reg.byte_in;
    assign cur_last = in_item_reg.last_byte;
    assign crlf     = (cur_byte == CHAR_LF) && prev_cr_reg;

    // per-method character match and exact-length pick
    always_comb
    begin
        exact_code = METHOD_NONE;
        for (int i = 0; i < NUM_METHODS; i++)
        begin
            keep[i] = (method_length_reg < METHOD_LEN[i]) &&
                      (METHOD_CHAR[i][method_length_reg[2:0]] == cur_byte);
        end
        for (int i = NUM_METHODS - 1; i >= 0; i--)
        begin
            if (candidates_reg[i] && (METHOD_LEN[i] == method_length_reg))
            begin
                exact_code = 4'(i + 1);
            end
        end
    end

    // parse step for the byte in the input register
    always_comb
    begin
        phase_next         = phase_reg;
        candidates_next    = candidates_reg;
        method_length_next = method_length_reg;
        uri_begin_next     = uri_begin_reg;
        uri_end_next       = uri_end_reg;
        version_begin_next = version_begin_reg;
        result_done_next   = result_done_reg;
        method_code_next   = method_code_reg;
        produce            = 1'b0;
        result             = '0;

        if (!result_done_reg)
        begin
            if (position_reg == POS_MAX)
            begin
                produce       = 1'b1;
                result.status = ST_TOO_LONG;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        if (cur_byte == CHAR_SP)
                        begin
                            if (exact_code == METHOD_NONE)
                            begin
                                produce       = 1'b1;
                                result.status = ST_UNKNOWN;
                            end
                            else
                            begin
                                phase_next       = PH_URI;
                                uri_begin_next   = position_reg + 1'b1;
                                method_code_next = exact_code;
                            end
                        end
                        else
                        begin
                            candidates_next = candidates_reg & keep;
                            if (method_length_reg != 4'hF)
                            begin
                                method_length_next = method_length_reg + 4'd1;
                            end
                        end
                    end
                    PH_URI:
                    begin
                        if (cur_byte == CHAR_SP)
                        begin
                            uri_end_next       = position_reg;
                            version_begin_next = position_reg + 1'b1;
                            phase_next         = PH_VERSION;
                        end
                        else if (crlf)
                        begin
                            produce              = 1'b1;
                            result.status        = ST_OK;
                            result.method_code   = method_code_reg;
                            result.uri_start     = 16'(uri_begin_reg);
                            result.uri_length    =
                                16'(position_reg - 1'b1 - uri_begin_reg);
                            result.header_offset = 16'(position_reg + 1'b1);
                        end
                    end
                    PH_VERSION:
                    begin
                        if (crlf)
                        begin
                            produce               = 1'b1;
                            result.status         = ST_OK;
                            result.method_code    = method_code_reg;
                            result.uri_start      = 16'(uri_begin_reg);
                            result.uri_length     = 16'(uri_end_reg - uri_begin_reg);
                            result.version_start  = 16'(version_begin_reg);
                            result.version_length =
                                16'(position_reg - 1'b1 - version_begin_reg);
                            result.header_offset  = 16'(position_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // buffer ends before the line is decided
            if (!produce && cur_last)
            begin
                produce       = 1'b1;
                result.status = (phase_next == PH_METHOD) ? ST_NO_SPACE : ST_NO_LINE_END;
            end

            if (produce)
            begin
                result_done_next = 1'b1;
            end
        end

        prev_cr_next  = (cur_byte == CHAR_CR);
        position_next = position_reg + 1'b1;

        // rearm for the next buffer
        if (cur_last)
        begin
            phase_next         = PH_METHOD;
            position_next      = '0;
            candidates_next    = '1;
            method_length_next = '0;
            prev_cr_next       = 1'b0;
            uri_begin_next     = '0;
            uri_end_next       = '0;
            version_begin_next = '0;
            result_done_next   = 1'b0;
            method_code_next   = METHOD_NONE;
        end
    end

    // handshake: a byte moves on unless its result finds the output full and not ready
    assign advance  = in_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_METHOD;
            position_reg      <= '0;
            candidates_reg    <= '1;
            method_length_reg <= '0;
            prev_cr_reg       <= 1'b0;
            uri_begin_reg     <= '0;
            uri_end_reg       <= '0;
            version_begin_reg <= '0;
            result_done_reg   <= 1'b0;
            method_code_reg   <= METHOD_NONE;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            position_reg      <= position_next;
            candidates_reg    <= candidates_next;
            method_length_reg <= method_length_next;
            prev_cr_reg       <= prev_cr_next;
            uri_begin_reg     <= uri_begin_next;
            uri_end_reg       <= uri_end_next;
            version_begin_reg <= version_begin_next;
            result_done_reg   <= result_done_next;
            method_code_reg   <= method_code_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/hrlp_checker.sv =====
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks on the request line parser, bound into the parser module.
// ----------------------------------------------------------------------------
module hrlp_checker
    import hrlp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // status stays within its codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= ST_TOO_LONG)
        else $error("status out of range");

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |->
            out_item.method_code == METHOD_NONE && out_item.uri_start == 16'd0 &&
            out_item.uri_length == 16'd0 && out_item.version_start == 16'd0 &&
            out_item.version_length == 16'd0 && out_item.header_offset == 16'd0)
        else $error("error result with nonzero fields");

    // a good result names a known method
    a_ok_method: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OK |->
            out_item.method_code != METHOD_NONE && out_item.method_code <= METHOD_LAST)
        else $error("good result without a method");

    // headers start two bytes after the last field of the line
    a_ok_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OK |->
            out_item.header_offset == ((out_item.version_start != 16'd0) ?
                16'(out_item.version_start + out_item.version_length + 16'd2) :
                16'(out_item.uri_start + out_item.uri_length + 16'd2)))
        else $error("header offset inconsistent with spans");

endmodule

bind http_request_line_parser_unit hrlp_checker u_hrlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
